>>> rtl/rhts_pkg.sv
// rhts_pkg: shared widths, constants, register indexes and structs for the
// rpm hold throttle stepper. No dependencies.
`default_nettype none

package rhts_pkg;

	localparam int TIME_WIDTH = 32;

	localparam int THR_W = 17;
	localparam int RPM_W = 16;
	localparam int TGT_W = 12;
	localparam int MS_W = 16;
	localparam int TOL_W = 10;

	localparam int RPM_PER_DOUBLING = 100;
	localparam int MAX_DOUBLINGS = 16;
	localparam int UNITS_W = $clog2(MAX_DOUBLINGS + 1);
	localparam int STEP_W = THR_W + MAX_DOUBLINGS;

	localparam logic [THR_W-1:0] FULL_THROTTLE = THR_W'(65536);

	// register indexes on the config port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 3'd4;

	localparam logic [TOL_W-1:0] TOLERANCE_RST = TOL_W'(15);
	localparam logic [MS_W-1:0] SETTLE_RST = MS_W'(2000);
	localparam logic [MS_W-1:0] MIN_INTERVAL_RST = MS_W'(1000);
	localparam logic [THR_W-1:0] BASE_STEP_RST = THR_W'(328);
	localparam logic [THR_W-1:0] MAX_STEP_RST = THR_W'(6554);

	// short queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [TOL_W-1:0] tolerance_rpm;
		logic [MS_W-1:0]  settle_ms;
		logic [MS_W-1:0]  min_interval_ms;
		logic [THR_W-1:0] base_step;
		logic [THR_W-1:0] max_step;
	} cfg_t;

	// one classified tick, ready for the timing decision
	typedef struct packed {
		logic [MS_W-1:0]  elapsed;
		logic             out_tol;
		logic [THR_W-1:0] thr_in;
		logic [THR_W-1:0] cand_thr;
		logic             differs;
	} qent_t;

endpackage

`default_nettype wire

>>> rtl/rpm_hold_throttle_stepper_core.sv
// rpm_hold_throttle_stepper_core: top level, config registers and the
// front / queue / back chain. Depends on rhts_pkg, rhts_front, rhts_queue, rhts_back.
//
//   channel  handshake          payload
//   in       in_valid/in_stall  elapsed_ms enable set_rpm measured_rpm throttle_in
//   out      out_valid/out_stall throttle_out adjusted out_of_tolerance
//   cfg      cfg_valid/cfg_ready cfg_index cfg_data
//
// a tick per cycle unless in_stall, one result per tick, via s1/queue/out regs
// the back's combinational age update (one add and compare) sets the rate
// reset clears the timing state and loads register defaults; no clearing pass
// the queue lets the front keep taking ticks while a result waits on out_stall
// cfg_ready is always high
`default_nettype none

module rpm_hold_throttle_stepper_core
	import rhts_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [MS_W-1:0]      elapsed_ms,
	input  wire logic                 enable,
	input  wire logic [TGT_W-1:0]     set_rpm,
	input  wire logic [RPM_W-1:0]     measured_rpm,
	input  wire logic [THR_W-1:0]     throttle_in,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [THR_W-1:0]          throttle_out,
	output logic                      adjusted,
	output logic                      out_of_tolerance,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [THR_W-1:0]     cfg_data
);

	cfg_t  cfg_q;
	logic  q_full;
	logic  q_push;
	qent_t q_wdata;
	logic  q_pop;
	logic  q_nonempty;
	qent_t q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tolerance_rpm   <= TOLERANCE_RST;
			cfg_q.settle_ms       <= SETTLE_RST;
			cfg_q.min_interval_ms <= MIN_INTERVAL_RST;
			cfg_q.base_step       <= BASE_STEP_RST;
			cfg_q.max_step        <= MAX_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TOLERANCE:    cfg_q.tolerance_rpm   <= cfg_data[TOL_W-1:0];
				REG_SETTLE:       cfg_q.settle_ms       <= cfg_data[MS_W-1:0];
				REG_MIN_INTERVAL: cfg_q.min_interval_ms <= cfg_data[MS_W-1:0];
				REG_BASE_STEP:    cfg_q.base_step       <= cfg_data;
				REG_MAX_STEP:     cfg_q.max_step        <= cfg_data;
				default: ;
			endcase
		end
	end

	rhts_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.elapsed_ms   (elapsed_ms),
		.enable       (enable),
		.set_rpm      (set_rpm),
		.measured_rpm (measured_rpm),
		.throttle_in  (throttle_in),
		.cfg          (cfg_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_wdata      (q_wdata)
	);

	rhts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	rhts_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_nonempty       (q_nonempty),
		.q_head           (q_head),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.throttle_out     (throttle_out),
		.adjusted         (adjusted),
		.out_of_tolerance (out_of_tolerance)
	);

endmodule

`default_nettype wire

>>> rtl/rhts_front.sv
// rhts_front: input stage, error classification and candidate throttle step.
// Depends on rhts_pkg.
`default_nettype none

module rhts_front
	import rhts_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [MS_W-1:0]  elapsed_ms,
	input  wire logic             enable,
	input  wire logic [TGT_W-1:0] set_rpm,
	input  wire logic [RPM_W-1:0] measured_rpm,
	input  wire logic [THR_W-1:0] throttle_in,
	input  wire cfg_t             cfg,
	input  wire logic             q_full,
	output logic                  q_push,
	output qent_t                 q_wdata
);

	logic             s1_v_q;
	logic [MS_W-1:0]  elapsed_s1;
	logic             out_tol_s1;
	logic             up_s1;
	logic [RPM_W-1:0] err_s1;
	logic [THR_W-1:0] thr_s1;

	logic             advance;
	logic             up;
	logic [RPM_W-1:0] err;
	logic [RPM_W-1:0] target_ext;

	logic [UNITS_W-1:0] units;
	logic [STEP_W-1:0]  step_wide;
	logic [THR_W-1:0]   step;
	logic [THR_W:0]     sum;
	logic [THR_W-1:0]   cand;

	assign advance  = !s1_v_q || !q_full;
	assign in_stall = s1_v_q && q_full;

	assign target_ext = RPM_W'(set_rpm);
	assign up  = target_ext > measured_rpm;
	assign err = up ? (target_ext - measured_rpm) : (measured_rpm - target_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (advance) begin
			s1_v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			elapsed_s1 <= elapsed_ms;
			out_tol_s1 <= enable && (err > RPM_W'(cfg.tolerance_rpm));
			up_s1      <= up;
			err_s1     <= err;
			thr_s1     <= throttle_in;
		end
	end

	// thermometer over whole hundreds of rpm, saturating
	always_comb begin
		units = '0;
		for (int k = 1; k <= MAX_DOUBLINGS; k++) begin
			if (err_s1 >= RPM_W'(k * RPM_PER_DOUBLING))
				units = UNITS_W'(k);
		end
	end

	assign step_wide = STEP_W'(cfg.base_step) << units;
	assign step = (step_wide > STEP_W'(cfg.max_step)) ? cfg.max_step : step_wide[THR_W-1:0];
	assign sum  = {1'b0, thr_s1} + {1'b0, step};

	always_comb begin
		if (up_s1) begin
			cand = (sum > (THR_W+1)'(FULL_THROTTLE)) ? FULL_THROTTLE : sum[THR_W-1:0];
		end else if (thr_s1 > step) begin
			cand = ((thr_s1 - step) > FULL_THROTTLE) ? FULL_THROTTLE : (thr_s1 - step);
		end else begin
			cand = '0;
		end
	end

	assign q_push           = s1_v_q && !q_full;
	assign q_wdata.elapsed  = elapsed_s1;
	assign q_wdata.out_tol  = out_tol_s1;
	assign q_wdata.thr_in   = thr_s1;
	assign q_wdata.cand_thr = cand;
	assign q_wdata.differs  = cand != thr_s1;

endmodule

`default_nettype wire

>>> rtl/rhts_queue.sv
// rhts_queue: short fifo of classified ticks between front and back.
// Depends on rhts_pkg.
`default_nettype none

module rhts_queue
	import rhts_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qent_t wdata,
	output logic       full,
	input  wire logic  pop,
	output logic       nonempty,
	output qent_t      head
);

	qent_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full     = count_q == QCNT_W'(QDEPTH);
	assign nonempty = count_q != '0;
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

endmodule

`default_nettype wire

>>> rtl/rhts_back.sv
// rhts_back: timing state (deviation age, time since adjust), adjust decision
// and output register. Depends on rhts_pkg.
`default_nettype none

module rhts_back
	import rhts_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  q_nonempty,
	input  wire qent_t q_head,
	output logic       q_pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic [THR_W-1:0] throttle_out,
	output logic       adjusted,
	output logic       out_of_tolerance
);

	// ages stand for running time minus the stored start / adjust times
	logic                  dev_active_q;
	logic [TIME_WIDTH-1:0] dev_age_q;
	logic [TIME_WIDTH-1:0] adj_age_q;

	logic                  out_v_q;
	logic [THR_W-1:0]      thr_out_q;
	logic                  adjusted_q;
	logic                  oot_q;

	logic [TIME_WIDTH-1:0] elapsed_ext;
	logic [TIME_WIDTH-1:0] since_dev;
	logic [TIME_WIDTH-1:0] since_adj;
	logic                  apply;
	logic                  adj_now;

	assign q_pop = q_nonempty && (!out_v_q || !out_stall);

	assign elapsed_ext = TIME_WIDTH'(q_head.elapsed);
	assign since_dev   = dev_active_q ? (dev_age_q + elapsed_ext) : '0;
	assign since_adj   = adj_age_q + elapsed_ext;
	assign apply = q_head.out_tol
		&& (since_dev >= TIME_WIDTH'(cfg.settle_ms))
		&& (since_adj >= TIME_WIDTH'(cfg.min_interval_ms));
	assign adj_now = apply && q_head.differs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_active_q <= 1'b0;
			dev_age_q    <= '0;
			adj_age_q    <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (q_pop) begin
				dev_active_q <= q_head.out_tol;
				dev_age_q    <= q_head.out_tol ? since_dev : '0;
				adj_age_q    <= adj_now ? '0 : since_adj;
				out_v_q      <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			thr_out_q  <= apply ? q_head.cand_thr : q_head.thr_in;
			adjusted_q <= adj_now;
			oot_q      <= q_head.out_tol;
		end
	end

	assign out_valid        = out_v_q;
	assign throttle_out     = thr_out_q;
	assign adjusted         = adjusted_q;
	assign out_of_tolerance = oot_q;

endmodule

`default_nettype wire

>>> rtl/rhts_checker.sv
// rhts_checker: port-level assertions for the stepper top level, and the bind
// that attaches them. Depends on rhts_pkg and rpm_hold_throttle_stepper_core.
`default_nettype none

module rhts_checker
	import rhts_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic [THR_W-1:0] throttle_out,
	input wire logic             adjusted,
	input wire logic             out_of_tolerance
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(throttle_out)
			&& $stable(adjusted) && $stable(out_of_tolerance))
		else $error("result beat changed while stalled");

	a_adj_needs_oot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && adjusted |-> out_of_tolerance)
		else $error("adjustment without out of tolerance");

	a_adj_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && adjusted |-> throttle_out <= FULL_THROTTLE)
		else $error("adjusted throttle above full");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result beat right after reset");

endmodule

bind rpm_hold_throttle_stepper_core rhts_checker u_rhts_checker (.*);

`default_nettype wire

>>> test/tb_rpm_hold_throttle_stepper_core.sv
// tb_rpm_hold_throttle_stepper_core: self-checking bench for the rpm hold throttle stepper,
// with directed ticks, random hold runs and register sweeps.
// Depends on rhts_pkg and rpm_hold_throttle_stepper_core.

module tb_rpm_hold_throttle_stepper_core;
	import rhts_pkg::*;

	typedef struct packed {
		logic [MS_W-1:0]  elapsed_ms;
		logic             enable;
		logic [TGT_W-1:0] set_rpm;
		logic [RPM_W-1:0] measured_rpm;
		logic [THR_W-1:0] throttle_in;
	} tick_t;

	typedef struct packed {
		logic [THR_W-1:0] throttle_out;
		logic             adjusted;
		logic             out_of_tolerance;
	} throttle_res_t;

	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_TICKS = 205;
	localparam int RANDOM_PHASES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [MS_W-1:0] elapsed_ms = '0;
	logic enable = 1'b0;
	logic [TGT_W-1:0] set_rpm = '0;
	logic [RPM_W-1:0] measured_rpm = '0;
	logic [THR_W-1:0] throttle_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [THR_W-1:0] throttle_out;
	logic adjusted;
	logic out_of_tolerance;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [THR_W-1:0] cfg_data = '0;

	rpm_hold_throttle_stepper_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.elapsed_ms(elapsed_ms),
		.enable(enable),
		.set_rpm(set_rpm),
		.measured_rpm(measured_rpm),
		.throttle_in(throttle_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.throttle_out(throttle_out),
		.adjusted(adjusted),
		.out_of_tolerance(out_of_tolerance),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// shadow registers and hold state
	logic [TOL_W-1:0] cfg_tol = TOLERANCE_RST;
	logic [MS_W-1:0] cfg_settle = SETTLE_RST;
	logic [MS_W-1:0] cfg_min_gap = MIN_INTERVAL_RST;
	logic [THR_W-1:0] cfg_base = BASE_STEP_RST;
	logic [THR_W-1:0] cfg_max = MAX_STEP_RST;
	logic [TIME_WIDTH-1:0] hold_time = '0;
	logic [TIME_WIDTH-1:0] dev_since = '0;
	logic dev_on = 1'b0;
	logic [TIME_WIDTH-1:0] last_change_time = '0;

	tick_t tick_backlog[$];
	throttle_res_t due_throttle_q[$];
	tick_t next_tick;
	tick_t took_tick;
	throttle_res_t want;
	logic tick_taken = 1'b0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int mismatch_cnt = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic void take_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [THR_W-1:0] data);
		case (idx)
			REG_TOLERANCE: cfg_tol = data[TOL_W-1:0];
			REG_SETTLE: cfg_settle = data[MS_W-1:0];
			REG_MIN_INTERVAL: cfg_min_gap = data[MS_W-1:0];
			REG_BASE_STEP: cfg_base = data;
			REG_MAX_STEP: cfg_max = data;
			default: ;
		endcase
	endfunction

	function automatic throttle_res_t step_throttle(input tick_t t);
		logic [TIME_WIDTH-1:0] since_dev;
		logic [TIME_WIDTH-1:0] since_adj;
		logic [RPM_W-1:0] err;
		logic up;
		int unsigned units;
		logic [63:0] step;
		logic [63:0] nt;
		throttle_res_t r;
		nt = 64'(t.throttle_in);
		r.out_of_tolerance = 1'b0;
		hold_time = hold_time + TIME_WIDTH'(t.elapsed_ms);
		if (!t.enable) begin
			dev_on = 1'b0;
		end else begin
			up = RPM_W'(t.set_rpm) > t.measured_rpm;
			err = up ? RPM_W'(t.set_rpm) - t.measured_rpm
				: t.measured_rpm - RPM_W'(t.set_rpm);
			if (err > cfg_tol) begin
				r.out_of_tolerance = 1'b1;
				if (!dev_on) begin
					dev_on = 1'b1;
					dev_since = hold_time;
				end
				since_dev = hold_time - dev_since;
				since_adj = hold_time - last_change_time;
				if (since_dev >= cfg_settle && since_adj >= cfg_min_gap) begin
					units = err / RPM_PER_DOUBLING;
					if (units > MAX_DOUBLINGS) units = MAX_DOUBLINGS;
					step = 64'(cfg_base) << units;
					if (step > cfg_max) step = 64'(cfg_max);
					if (up) nt = 64'(t.throttle_in) + step;
					else nt = (t.throttle_in > step) ? 64'(t.throttle_in) - step : 64'd0;
					if (nt > FULL_THROTTLE) nt = 64'(FULL_THROTTLE);
					if (nt != t.throttle_in) last_change_time = hold_time;
				end
			end else begin
				dev_on = 1'b0;
			end
		end
		r.throttle_out = nt[THR_W-1:0];
		r.adjusted = (nt != t.throttle_in);
		return r;
	endfunction

	task automatic note_fault(input string msg);
		mismatch_cnt++;
		$error("%s", msg);
	endtask

	task automatic check_field(input string field, input logic [THR_W-1:0] want_v,
			input logic [THR_W-1:0] got_v);
		if (got_v !== want_v)
			note_fault($sformatf("%s: expected %0d, got %0d", field, want_v, got_v));
	endtask

	// tick driver: a new beat only once the previous one was taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || tick_taken) begin
				if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_tick = tick_backlog.pop_front();
					elapsed_ms <= next_tick.elapsed_ms;
					enable <= next_tick.enable;
					set_rpm <= next_tick.set_rpm;
					measured_rpm <= next_tick.measured_rpm;
					throttle_in <= next_tick.throttle_in;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor: checks result beats, tracks register writes, predicts taken ticks
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_throttle_q.size() == 0) begin
					note_fault($sformatf("result beat with nothing due: throttle_out %0d",
						throttle_out));
				end else begin
					want = due_throttle_q.pop_front();
					check_field("throttle_out", want.throttle_out, throttle_out);
					check_field("adjusted", THR_W'(want.adjusted), THR_W'(adjusted));
					check_field("out_of_tolerance", THR_W'(want.out_of_tolerance),
						THR_W'(out_of_tolerance));
				end
			end
			if (cfg_valid && cfg_ready) take_reg_write(cfg_index, cfg_data);
			if (in_valid && !in_stall) begin
				took_tick.elapsed_ms = elapsed_ms;
				took_tick.enable = enable;
				took_tick.set_rpm = set_rpm;
				took_tick.measured_rpm = measured_rpm;
				took_tick.throttle_in = throttle_in;
				due_throttle_q.push_back(step_throttle(took_tick));
			end
			tick_taken <= in_valid && !in_stall;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_config(input logic [THR_W-1:0] tol, input logic [THR_W-1:0] settle,
			input logic [THR_W-1:0] gap, input logic [THR_W-1:0] base,
			input logic [THR_W-1:0] top);
		write_reg(REG_TOLERANCE, tol);
		write_reg(REG_SETTLE, settle);
		write_reg(REG_MIN_INTERVAL, gap);
		write_reg(REG_BASE_STEP, base);
		write_reg(REG_MAX_STEP, top);
	endtask

	function automatic logic [THR_W-1:0] pick_ms_reg();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 50) return THR_W'($urandom_range(0, 3000));
		if (sel < 75) return THR_W'($urandom_range(0, 65535));
		return THR_W'($urandom);
	endfunction

	task automatic write_random_config();
		logic [THR_W-1:0] tol;
		logic [THR_W-1:0] base;
		logic [THR_W-1:0] top;
		tol = ($urandom_range(3) == 0) ? THR_W'($urandom) : THR_W'($urandom_range(0, 60));
		if ($urandom_range(9) < 7) base = THR_W'($urandom_range(0, 2000));
		else base = $urandom_range(1) ? '0 : THR_W'($urandom);
		top = ($urandom_range(9) < 7) ? THR_W'($urandom_range(0, 20000)) : THR_W'($urandom);
		apply_config(tol, pick_ms_reg(), pick_ms_reg(), base, top);
	endtask

	function automatic logic [MS_W-1:0] pick_elapsed();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 50) return MS_W'($urandom_range(0, 250));
		if (sel < 80) return MS_W'($urandom_range(0, 2500));
		if (sel < 90) return MS_W'($urandom);
		if (sel < 95) return '0;
		return '1;
	endfunction

	function automatic logic [TGT_W-1:0] pick_target();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 80) return TGT_W'($urandom_range(0, 2500));
		if (sel < 90) return TGT_W'($urandom_range(2501, 4095));
		if (sel < 95) return '0;
		return '1;
	endfunction

	function automatic logic [THR_W-1:0] pick_throttle();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 10) return THR_W'($urandom_range(0, 400));
		if (sel < 20) return THR_W'($urandom_range(65100, 65536));
		if (sel < 30) return THR_W'($urandom_range(65537, 131071));
		if (sel < 35) return '0;
		if (sel < 40) return FULL_THROTTLE;
		return THR_W'($urandom_range(0, 65536));
	endfunction

	// mostly within 2000 rpm of the target, often near the tolerance band, sometimes anywhere
	function automatic logic [RPM_W-1:0] pick_measured(input logic [TGT_W-1:0] tgt);
		int unsigned sel;
		int unsigned err;
		int unsigned sum;
		sel = $urandom_range(99);
		if (sel < 15) return RPM_W'($urandom);
		if (sel < 40) err = $urandom_range(0, cfg_tol);
		else if (sel < 50) err = cfg_tol + $urandom_range(0, 1);
		else err = $urandom_range(0, 2000);
		if ($urandom_range(1)) return (tgt >= err) ? RPM_W'(tgt - err) : '0;
		sum = tgt + err;
		return (sum > 65535) ? '1 : RPM_W'(sum);
	endfunction

	task automatic queue_tick(input logic [MS_W-1:0] ms, input logic en,
			input logic [TGT_W-1:0] tgt, input logic [RPM_W-1:0] meas,
			input logic [THR_W-1:0] thr);
		tick_t t;
		t.elapsed_ms = ms;
		t.enable = en;
		t.set_rpm = tgt;
		t.measured_rpm = meas;
		t.throttle_in = thr;
		tick_backlog.push_back(t);
	endtask

	// a run of ticks around one target, as a real hold loop would see
	task automatic queue_hold_run(input logic long_gaps);
		tick_t t;
		int len;
		len = $urandom_range(3, 20);
		t.set_rpm = pick_target();
		t.throttle_in = pick_throttle();
		repeat (len) begin
			t.elapsed_ms = long_gaps ? '1 : pick_elapsed();
			t.enable = ($urandom_range(19) != 0);
			t.measured_rpm = pick_measured(t.set_rpm);
			tick_backlog.push_back(t);
			if ($urandom_range(9) < 3) t.throttle_in = pick_throttle();
		end
	endtask

	task automatic queue_random(input int n, input logic long_gaps);
		while (tick_backlog.size() < n) begin
			if ($urandom_range(4) == 0) begin
				repeat ($urandom_range(1, 3))
					queue_tick(MS_W'($urandom), 1'($urandom), TGT_W'($urandom),
						RPM_W'($urandom), THR_W'($urandom));
			end else begin
				queue_hold_run(long_gaps);
			end
		end
	endtask

	task automatic wait_results_in();
		@(negedge clk);
		while (tick_backlog.size() != 0 || in_valid || due_throttle_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 0; stall_pct = 0; end
			1: begin send_idle_pct = 64; stall_pct = 0; end
			2: begin send_idle_pct = 0; stall_pct = 64; end
			default: begin send_idle_pct = 27; stall_pct = 27; end
		endcase
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values
		queue_tick(16'd0, 1'b0, 12'd0, 16'd0, 17'd0);
		queue_tick(16'd65535, 1'b0, 12'd4095, 16'd65535, 17'd131071);
		queue_tick(16'd0, 1'b1, 12'd1000, 16'd1015, 17'd30000);
		queue_tick(16'd0, 1'b1, 12'd1000, 16'd985, 17'd30000);
		queue_tick(16'd0, 1'b1, 12'd1016, 16'd1000, 17'd30000);
		queue_tick(16'd2000, 1'b1, 12'd1016, 16'd1000, 17'd30000);
		queue_tick(16'd500, 1'b1, 12'd1016, 16'd1000, 17'd30328);
		queue_tick(16'd500, 1'b1, 12'd1016, 16'd1000, 17'd30328);
		queue_tick(16'd1000, 1'b1, 12'd0, 16'd65535, 17'd3000);
		// pinned at zero: no change, so the adjust time must stay put
		queue_tick(16'd1000, 1'b1, 12'd0, 16'd65535, 17'd0);
		queue_tick(16'd0, 1'b1, 12'd2000, 16'd1000, 17'd100);
		// throttle above full
		queue_tick(16'd1000, 1'b1, 12'd1200, 16'd1000, 17'd131071);
		queue_tick(16'd1000, 1'b1, 12'd1000, 16'd1200, 17'd100000);
		queue_tick(16'd0, 1'b1, 12'd1000, 16'd1000, 17'd70000);
		queue_tick(16'd0, 1'b1, 12'd1200, 16'd1000, 17'd65536);
		queue_tick(16'd2000, 1'b1, 12'd1200, 16'd1000, 17'd65536);
		// disable drops the deviation start
		queue_tick(16'd0, 1'b0, 12'd1200, 16'd1000, 17'd40000);
		queue_tick(16'd3000, 1'b1, 12'd1200, 16'd1000, 17'd40000);
		// doubling boundaries and saturation
		queue_tick(16'd2000, 1'b1, 12'd1199, 16'd1000, 17'd40000);
		queue_tick(16'd1000, 1'b1, 12'd1200, 16'd1000, 17'd40000);
		queue_tick(16'd1000, 1'b1, 12'd1499, 16'd1000, 17'd40000);
		queue_tick(16'd1000, 1'b1, 12'd1500, 16'd1000, 17'd40000);
		queue_tick(16'd1000, 1'b1, 12'd2600, 16'd1000, 17'd40000);
		queue_tick(16'd1000, 1'b1, 12'd2700, 16'd1000, 17'd40000);
		queue_tick(16'd1000, 1'b1, 12'd4095, 16'd0, 17'd40000);
		wait_results_in();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: apply_config(THR_W'(TOLERANCE_RST), THR_W'(SETTLE_RST),
					THR_W'(MIN_INTERVAL_RST), BASE_STEP_RST, MAX_STEP_RST);
				1: apply_config('0, '0, '0, '0, '0);
				2: apply_config('1, '1, '1, '1, '1);
				// unit base and open cap make the doubling limit visible
				3: apply_config(THR_W'($urandom_range(0, 40)), '0, '0, THR_W'(1), '1);
				default: write_random_config();
			endcase
			if (p == 4) begin
				for (int i = REG_MAX_STEP + 1; i < (1 << CFG_IDX_W); i++)
					write_reg(CFG_IDX_W'(i), THR_W'($urandom));
			end
			@(posedge clk);
			set_idling(p % 4);
			queue_random(PHASE_TICKS, 1'b0);
			wait_results_in();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_throttle_q.size() != 0)
			note_fault($sformatf("%0d results never arrived", due_throttle_q.size()));
		if (mismatch_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
